>>> rtl/tt_pkg.sv
// Shared types and constants for the tap tempo metronome core.
// Used by every module under rtl; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package tt_pkg;

    localparam int OP_W       = 3;
    localparam int REQ_W      = 10;
    localparam int TEMPO_W    = 8;
    localparam int IVL_W      = 11;
    localparam int TMO_W      = 16;
    localparam int PULSE_W    = 8;
    localparam int DIV_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
    localparam logic [OP_W-1:0] OP_TAP       = 3'd1;
    localparam logic [OP_W-1:0] OP_START     = 3'd2;
    localparam logic [OP_W-1:0] OP_STOP      = 3'd3;
    localparam logic [OP_W-1:0] OP_SET_TEMPO = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_GIG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_TMO    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_LEN  = 2'd2;

    localparam logic [DIV_W-1:0]   MS_PER_MIN     = 16'd60000;
    localparam logic [TEMPO_W-1:0] TEMPO_MIN      = 8'd40;
    localparam logic [TEMPO_W-1:0] TEMPO_MAX      = 8'd240;
    localparam logic [TEMPO_W-1:0] TEMPO_RESET    = 8'd120;
    localparam logic [IVL_W-1:0]   INTERVAL_RESET = 11'd500;
    localparam logic [TMO_W-1:0]   TMO_RESET      = 16'd2000;
    localparam logic [PULSE_W-1:0] PULSE_RESET    = 8'd50;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [REQ_W-1:0] tempo_value;
        logic             display_active;
    } tt_in_t;

    typedef struct packed {
        logic               light;
        logic               beat;
        logic [TEMPO_W-1:0] tempo_now;
        logic               tapping;
        logic               is_running;
    } tt_out_t;

    // Commands from the sequencer to the serial time unit.
    typedef struct packed {
        logic start;
        logic incr;
        logic copy_beat;
        logic copy_tap;
    } alu_ctl_t;

    // Results of one serial pass, valid from the cycle done is high.
    typedef struct packed {
        logic             done;
        logic             expired;
        logic             beat_due;
        logic             gap_nz;
        logic             gap_lt;
        logic [DIV_W-1:0] gap;
    } alu_stat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_TAP,
        S_TAPDIV,
        S_IVL,
        S_FINISH
    } state_t;

endpackage

`default_nettype wire

>>> rtl/tt_serial_div.sv
// Restoring divider: 60000 divided by a 16-bit divisor, one quotient bit per cycle.
// Depends on tt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tt_serial_div
    import tt_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DIV_W-1:0] divisor,
    output logic                  done,
    output logic [DIV_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

    logic             active_reg, active_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] q_reg, q_next;
    logic [DIV_W-1:0] dvs_reg, dvs_next;
    logic [DIV_W+1:0] trial;

    // The dividend shifts out of the top of q_reg while quotient bits enter at the bottom.
    assign trial = {1'b0, rem_reg, q_reg[DIV_W-1]} - {2'b00, dvs_reg};

    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        q_next      = q_reg;
        dvs_next    = dvs_reg;
        if (start && !active_reg)
        begin
            active_next = 1'b1;
            cnt_next    = '0;
            rem_next    = '0;
            q_next      = MS_PER_MIN;
            dvs_next    = divisor;
        end
        else if (active_reg)
        begin
            if (trial[DIV_W+1])
            begin
                rem_next = {rem_reg[DIV_W-2:0], q_reg[DIV_W-1]};
                q_next   = {q_reg[DIV_W-2:0], 1'b0};
            end
            else
            begin
                rem_next = trial[DIV_W-1:0];
                q_next   = {q_reg[DIV_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

>>> rtl/tt_time_alu.sv
// Bit-serial time unit: holds the ms clock and the beat and tap stamps in rotating
// shift registers and works out increments, differences and compares LSB first.
// Depends on tt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tt_time_alu
    import tt_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire alu_ctl_t         ctl,
    input  wire logic [TMO_W-1:0] timeout,
    input  wire logic [IVL_W-1:0] interval,
    output alu_stat_t             stat
);

    localparam int CNT_W = $clog2(TIME_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TIME_BITS - 1);

    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [TIME_BITS-1:0] beat_ms_reg, beat_ms_next;
    logic [TIME_BITS-1:0] tap_ms_reg, tap_ms_next;
    logic [TIME_BITS-1:0] gap_reg, gap_next;
    logic [TMO_W-1:0]     tmo_sh_reg, tmo_sh_next;
    logic [IVL_W-1:0]     ivl_sh_reg, ivl_sh_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 active_reg, active_next;
    logic                 done_reg, done_next;
    logic                 carry_reg, carry_next;
    logic                 btap_reg, btap_next;
    logic                 bbeat_reg, bbeat_next;
    logic                 bgt_reg, bgt_next;
    logic                 blt_reg, blt_next;
    logic                 bge_reg, bge_next;
    logic                 nz_reg, nz_next;

    logic s_bit, lt_bit, lb_bit, dt_bit, db_bit, t_bit, i_bit;

    always_comb
    begin
        s_bit  = now_reg[0] ^ carry_reg;
        lt_bit = tap_ms_reg[0];
        lb_bit = beat_ms_reg[0];
        t_bit  = tmo_sh_reg[0];
        i_bit  = ivl_sh_reg[0];
        dt_bit = s_bit ^ lt_bit ^ btap_reg;
        db_bit = s_bit ^ lb_bit ^ bbeat_reg;
    end

    always_comb
    begin
        now_next     = now_reg;
        beat_ms_next = beat_ms_reg;
        tap_ms_next  = tap_ms_reg;
        gap_next     = gap_reg;
        tmo_sh_next  = tmo_sh_reg;
        ivl_sh_next  = ivl_sh_reg;
        cnt_next     = cnt_reg;
        active_next  = active_reg;
        done_next    = 1'b0;
        carry_next   = carry_reg;
        btap_next    = btap_reg;
        bbeat_next   = bbeat_reg;
        bgt_next     = bgt_reg;
        blt_next     = blt_reg;
        bge_next     = bge_reg;
        nz_next      = nz_reg;
        if (ctl.start && !active_reg)
        begin
            active_next = 1'b1;
            cnt_next    = '0;
            carry_next  = ctl.incr;
            btap_next   = 1'b0;
            bbeat_next  = 1'b0;
            bgt_next    = 1'b0;
            blt_next    = 1'b0;
            bge_next    = 1'b0;
            nz_next     = 1'b0;
            tmo_sh_next = timeout;
            ivl_sh_next = interval;
        end
        else if (active_reg)
        begin
            // The clock and stamp registers rotate once around; the updated clock bit re-enters at the top.
            now_next     = {s_bit, now_reg[TIME_BITS-1:1]};
            tap_ms_next  = {lt_bit, tap_ms_reg[TIME_BITS-1:1]};
            beat_ms_next = {lb_bit, beat_ms_reg[TIME_BITS-1:1]};
            gap_next     = {dt_bit, gap_reg[TIME_BITS-1:1]};
            tmo_sh_next  = {1'b0, tmo_sh_reg[TMO_W-1:1]};
            ivl_sh_next  = {1'b0, ivl_sh_reg[IVL_W-1:1]};
            carry_next   = now_reg[0] & carry_reg;
            btap_next    = (~s_bit & lt_bit) | (~(s_bit ^ lt_bit) & btap_reg);
            bbeat_next   = (~s_bit & lb_bit) | (~(s_bit ^ lb_bit) & bbeat_reg);
            // A final borrow of timeout minus gap means the gap exceeds the timeout.
            bgt_next     = (~t_bit & dt_bit) | (~(t_bit ^ dt_bit) & bgt_reg);
            blt_next     = (~dt_bit & t_bit) | (~(dt_bit ^ t_bit) & blt_reg);
            bge_next     = (~db_bit & i_bit) | (~(db_bit ^ i_bit) & bge_reg);
            nz_next      = nz_reg | dt_bit;
            cnt_next     = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
        else
        begin
            if (ctl.copy_beat)
            begin
                beat_ms_next = now_reg;
            end
            if (ctl.copy_tap)
            begin
                tap_ms_next = now_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg     <= '0;
            beat_ms_reg <= '0;
            tap_ms_reg  <= '0;
            cnt_reg     <= '0;
            active_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            now_reg     <= now_next;
            beat_ms_reg <= beat_ms_next;
            tap_ms_reg  <= tap_ms_next;
            cnt_reg     <= cnt_next;
            active_reg  <= active_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gap_reg    <= gap_next;
        tmo_sh_reg <= tmo_sh_next;
        ivl_sh_reg <= ivl_sh_next;
        carry_reg  <= carry_next;
        btap_reg   <= btap_next;
        bbeat_reg  <= bbeat_next;
        bgt_reg    <= bgt_next;
        blt_reg    <= blt_next;
        bge_reg    <= bge_next;
        nz_reg     <= nz_next;
    end

    always_comb
    begin
        stat.done     = done_reg;
        stat.expired  = bgt_reg;
        stat.beat_due = ~bge_reg;
        stat.gap_nz   = nz_reg;
        stat.gap_lt   = blt_reg;
        stat.gap      = gap_reg[DIV_W-1:0];
    end

endmodule

`default_nettype wire

>>> rtl/tap_tempo_metronome_core.sv
// Tap tempo metronome: takes one event word per item (ms tick, tap, start, stop, set
// tempo) and returns one status word per item. The time stamps are processed one bit
// per cycle by the serial time unit, and each division of 60000 runs in the shared
// restoring divider. One item is in work at a time; a finished word waits in the
// output register without holding off the next input word. Configuration must be
// written through a plain write port only while the block is idle; the block itself
// does not enforce this. Depends on tt_pkg, tt_time_alu and tt_serial_div.
`timescale 1ns / 1ps
`default_nettype none

module tap_tempo_metronome_core
    import tt_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire tt_in_t                in_word,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output tt_out_t                    out_word,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    state_t state_reg, state_next;

    tt_in_t             in_reg, in_next;
    tt_out_t            out_reg, out_next;
    logic               out_valid_reg, out_valid_next;
    logic               gig_reg;
    logic [TMO_W-1:0]   tmo_reg;
    logic [PULSE_W-1:0] pulse_cfg_reg;
    logic [TEMPO_W-1:0] tempo_reg, tempo_next;
    logic [TEMPO_W-1:0] cand_reg, cand_next;
    logic [IVL_W-1:0]   ivl_reg, ivl_next;
    logic [PULSE_W-1:0] pulse_reg, pulse_next;
    logic               run_reg, run_next;
    logic               tap_reg, tap_next;
    logic               beat_reg, beat_next;

    alu_ctl_t           alu_ctl;
    alu_stat_t          alu_stat;
    logic               div_start;
    logic [DIV_W-1:0]   div_divisor;
    logic               div_done;
    logic [DIV_W-1:0]   div_q;

    logic               in_fire;
    logic               out_free;
    logic [TEMPO_W-1:0] clamped;
    logic               q_in_range;
    logic               run_eff;
    logic [PULSE_W-1:0] pulse_dec;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        if (in_word.tempo_value < REQ_W'(TEMPO_MIN))
        begin
            clamped = TEMPO_MIN;
        end
        else if (in_word.tempo_value > REQ_W'(TEMPO_MAX))
        begin
            clamped = TEMPO_MAX;
        end
        else
        begin
            clamped = in_word.tempo_value[TEMPO_W-1:0];
        end
    end

    assign q_in_range = (div_q >= DIV_W'(TEMPO_MIN)) && (div_q <= DIV_W'(TEMPO_MAX));
    assign pulse_dec  = (pulse_reg != '0) ? pulse_reg - 1'b1 : '0;
    assign run_eff    = run_reg || (tap_reg && alu_stat.expired);

    tt_time_alu #(
        .TIME_BITS (TIME_BITS)
    ) u_time (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (alu_ctl),
        .timeout  (tmo_reg),
        .interval (ivl_reg),
        .stat     (alu_stat)
    );

    tt_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (in_word.op)
                        OP_TICK:      state_next = S_TICK;
                        OP_TAP:       state_next = tap_reg ? S_TAP : S_FINISH;
                        OP_SET_TEMPO: state_next = S_IVL;
                        default:      state_next = S_FINISH;
                    endcase
                end
            end
            S_TICK:
            begin
                if (alu_stat.done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_TAP:
            begin
                if (alu_stat.done)
                begin
                    state_next = (alu_stat.gap_nz && alu_stat.gap_lt) ? S_TAPDIV : S_FINISH;
                end
            end
            S_TAPDIV:
            begin
                if (div_done)
                begin
                    state_next = q_in_range ? S_IVL : S_FINISH;
                end
            end
            S_IVL:
            begin
                if (div_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs and datapath updates.
    always_comb
    begin
        in_next        = in_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        tempo_next     = tempo_reg;
        cand_next      = cand_reg;
        ivl_next       = ivl_reg;
        pulse_next     = pulse_reg;
        run_next       = run_reg;
        tap_next       = tap_reg;
        beat_next      = beat_reg;
        alu_ctl        = '0;
        div_start      = 1'b0;
        div_divisor    = {{(DIV_W-TEMPO_W){1'b0}}, cand_reg};

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    in_next   = in_word;
                    beat_next = 1'b0;
                    unique case (in_word.op)
                        OP_TICK:
                        begin
                            alu_ctl.start = 1'b1;
                            alu_ctl.incr  = 1'b1;
                        end
                        OP_TAP:
                        begin
                            if (tap_reg)
                            begin
                                alu_ctl.start = 1'b1;
                            end
                            else
                            begin
                                tap_next         = 1'b1;
                                alu_ctl.copy_tap = 1'b1;
                            end
                        end
                        OP_START:
                        begin
                            run_next = 1'b1;
                            tap_next = 1'b0;
                        end
                        OP_STOP:
                        begin
                            run_next   = 1'b0;
                            tap_next   = 1'b0;
                            pulse_next = '0;
                        end
                        OP_SET_TEMPO:
                        begin
                            cand_next   = clamped;
                            div_start   = 1'b1;
                            div_divisor = {{(DIV_W-TEMPO_W){1'b0}}, clamped};
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_TICK:
            begin
                if (alu_stat.done)
                begin
                    pulse_next = pulse_dec;
                    if (tap_reg && alu_stat.expired)
                    begin
                        tap_next = 1'b0;
                        run_next = 1'b1;
                    end
                    if (!run_eff || (gig_reg && !in_reg.display_active))
                    begin
                        pulse_next = '0;
                    end
                    else if (alu_stat.beat_due)
                    begin
                        beat_next         = 1'b1;
                        pulse_next        = pulse_cfg_reg;
                        alu_ctl.copy_beat = 1'b1;
                    end
                end
            end
            S_TAP:
            begin
                if (alu_stat.done)
                begin
                    alu_ctl.copy_tap = 1'b1;
                    if (alu_stat.gap_nz && alu_stat.gap_lt)
                    begin
                        div_start   = 1'b1;
                        div_divisor = alu_stat.gap;
                    end
                end
            end
            S_TAPDIV:
            begin
                if (div_done && q_in_range)
                begin
                    cand_next   = div_q[TEMPO_W-1:0];
                    div_start   = 1'b1;
                    div_divisor = div_q;
                end
            end
            S_IVL:
            begin
                if (div_done)
                begin
                    tempo_next = cand_reg;
                    ivl_next   = div_q[IVL_W-1:0];
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    out_next.light      = (pulse_reg != '0);
                    out_next.beat       = beat_reg;
                    out_next.tempo_now  = tempo_reg;
                    out_next.tapping    = tap_reg;
                    out_next.is_running = run_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            tempo_reg     <= TEMPO_RESET;
            ivl_reg       <= INTERVAL_RESET;
            pulse_reg     <= '0;
            run_reg       <= 1'b0;
            tap_reg       <= 1'b0;
            beat_reg      <= 1'b0;
            gig_reg       <= 1'b0;
            tmo_reg       <= TMO_RESET;
            pulse_cfg_reg <= PULSE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            tempo_reg     <= tempo_next;
            ivl_reg       <= ivl_next;
            pulse_reg     <= pulse_next;
            run_reg       <= run_next;
            tap_reg       <= tap_next;
            beat_reg      <= beat_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_GIG_MODE:  gig_reg       <= cfg_data[0];
                    CFG_TAP_TMO:   tmo_reg       <= cfg_data[TMO_W-1:0];
                    CFG_PULSE_LEN: pulse_cfg_reg <= cfg_data[PULSE_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg   <= in_next;
        out_reg  <= out_next;
        cand_reg <= cand_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    // The tempo stays in its legal range.
    a_tempo_range: assert property (@(posedge clk) disable iff (!rst_n)
        (tempo_reg >= TEMPO_MIN) && (tempo_reg <= TEMPO_MAX))
        else $error("tempo left its legal range");

    // The beat interval is always the whole-ms quotient of 60000 by the tempo.
    a_interval_match: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(ivl_reg) * 32'(tempo_reg) <= 32'(MS_PER_MIN)) &&
        (32'(ivl_reg) * 32'(tempo_reg) + 32'(tempo_reg) > 32'(MS_PER_MIN)))
        else $error("beat interval does not match tempo");

    // A beat is only reported while the metronome runs.
    a_beat_running: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) && beat_reg |-> run_reg)
        else $error("beat reported while stopped");

    // Only one item is in work at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("new word accepted while one is in work");

endmodule

`default_nettype wire

>>> sim/tt_status_checker.sv
// Status checker for the tap tempo metronome core: watches the event, status and
// register ports, predicts each status word and compares it with what the core returns.
// Depends on tt_pkg.
`timescale 1ns / 1ps

module tt_status_checker
    import tt_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  tt_in_t                in_word,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  tt_out_t               out_word,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending,
    output int                    beats
);

    // Register copies.
    logic               gig_mode;
    logic [TMO_W-1:0]   tap_limit;
    logic [PULSE_W-1:0] pulse_len;

    // Metronome state as the core should hold it.
    logic [TIME_BITS-1:0] clock_ms;
    logic [TIME_BITS-1:0] beat_stamp;
    logic [TIME_BITS-1:0] tap_stamp;
    logic [TEMPO_W-1:0]   bpm;
    logic [IVL_W-1:0]     beat_ivl;
    logic                 running;
    logic                 tap_mode;
    logic [PULSE_W-1:0]   pulse_cnt;

    tt_out_t status_due_q[$];

    task automatic set_tempo(input int unsigned bpm_req);
        int unsigned b;
        begin
            b = bpm_req;
            if (b < TEMPO_MIN)
            begin
                b = TEMPO_MIN;
            end
            if (b > TEMPO_MAX)
            begin
                b = TEMPO_MAX;
            end
            bpm      = b[TEMPO_W-1:0];
            beat_ivl = IVL_W'(MS_PER_MIN / b);
        end
    endtask

    task automatic advance_metronome(input tt_in_t w, output tt_out_t r);
        logic [TIME_BITS-1:0] since;
        int unsigned          tap_bpm;
        logic                 fired;
        begin
            fired = 1'b0;
            case (w.op)
                OP_TICK:
                begin
                    clock_ms = clock_ms + 1'b1;
                    if (pulse_cnt != '0)
                    begin
                        pulse_cnt = pulse_cnt - 1'b1;
                    end
                    since = clock_ms - tap_stamp;
                    if (tap_mode && since > tap_limit)
                    begin
                        tap_mode = 1'b0;
                        running  = 1'b1;
                    end
                    since = clock_ms - beat_stamp;
                    if (!running || (gig_mode && !w.display_active))
                    begin
                        pulse_cnt = '0;
                    end
                    else if (since >= beat_ivl)
                    begin
                        fired      = 1'b1;
                        pulse_cnt  = pulse_len;
                        beat_stamp = clock_ms;
                    end
                end
                OP_TAP:
                begin
                    if (!tap_mode)
                    begin
                        tap_mode = 1'b1;
                    end
                    else
                    begin
                        since = clock_ms - tap_stamp;
                        // The gap is below the 16-bit timeout here, so it fits in 32 bits.
                        if (since != '0 && since < tap_limit)
                        begin
                            tap_bpm = MS_PER_MIN / 32'(since);
                            if (tap_bpm >= TEMPO_MIN && tap_bpm <= TEMPO_MAX)
                            begin
                                set_tempo(tap_bpm);
                            end
                        end
                    end
                    tap_stamp = clock_ms;
                end
                OP_START:
                begin
                    running  = 1'b1;
                    tap_mode = 1'b0;
                end
                OP_STOP:
                begin
                    running   = 1'b0;
                    tap_mode  = 1'b0;
                    pulse_cnt = '0;
                end
                OP_SET_TEMPO:
                begin
                    set_tempo(w.tempo_value);
                end
                default:
                begin
                end
            endcase
            r.light      = (pulse_cnt != '0);
            r.beat       = fired;
            r.tempo_now  = bpm;
            r.tapping    = tap_mode;
            r.is_running = running;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        tt_out_t due;
        tt_out_t fresh;
        if (!rst_n)
        begin
            gig_mode   = 1'b0;
            tap_limit  = TMO_RESET;
            pulse_len  = PULSE_RESET;
            clock_ms   = '0;
            beat_stamp = '0;
            tap_stamp  = '0;
            bpm        = TEMPO_RESET;
            beat_ivl   = INTERVAL_RESET;
            running    = 1'b0;
            tap_mode   = 1'b0;
            pulse_cnt  = '0;
            status_due_q.delete();
            errors  = 0;
            pending = 0;
            beats   = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_GIG_MODE:  gig_mode  = cfg_data[0];
                    CFG_TAP_TMO:   tap_limit = cfg_data[TMO_W-1:0];
                    CFG_PULSE_LEN: pulse_len = cfg_data[PULSE_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            // A status word can only belong to an event taken at an earlier edge.
            if (out_valid && out_ready)
            begin
                if (status_due_q.size() == 0)
                begin
                    $error("status word %h arrived with none expected", out_word);
                    errors++;
                end
                else
                begin
                    due = status_due_q.pop_front();
                    if (out_word.light !== due.light)
                    begin
                        $error("light: expected %0d, got %0d", due.light, out_word.light);
                        errors++;
                    end
                    if (out_word.beat !== due.beat)
                    begin
                        $error("beat: expected %0d, got %0d", due.beat, out_word.beat);
                        errors++;
                    end
                    if (out_word.tempo_now !== due.tempo_now)
                    begin
                        $error("tempo_now: expected %0d, got %0d",
                               due.tempo_now, out_word.tempo_now);
                        errors++;
                    end
                    if (out_word.tapping !== due.tapping)
                    begin
                        $error("tapping: expected %0d, got %0d", due.tapping, out_word.tapping);
                        errors++;
                    end
                    if (out_word.is_running !== due.is_running)
                    begin
                        $error("is_running: expected %0d, got %0d",
                               due.is_running, out_word.is_running);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                advance_metronome(in_word, fresh);
                status_due_q.push_back(fresh);
                if (fresh.beat)
                begin
                    beats++;
                end
            end
            pending = status_due_q.size();
        end
    end

endmodule

>>> sim/tap_tempo_metronome_core_tb.sv
// Top of the tap tempo metronome testbench: clock, reset, event and register stimulus,
// random stalls on both channels and the final verdict.
// Depends on tt_pkg, tap_tempo_metronome_core and tt_status_checker.
`timescale 1ns / 1ps

module tap_tempo_metronome_core_tb
    import tt_pkg::*;
();

    localparam int TIME_BITS = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE      = 2'd3;
    localparam logic [OP_W-1:0]      OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0]      OP_SPARE_LAST  = 3'd7;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    tt_in_t                in_word   = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_ready;
    logic                  out_valid;
    tt_out_t               out_word;

    int send_idle_pct = 36;
    int recv_idle_pct = 86;
    int n_ticks       = 0;
    int n_taps        = 0;
    int n_sets        = 0;
    int n_runstop     = 0;
    int n_spare       = 0;
    int checker_errors;
    int checker_pending;
    int checker_beats;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    tap_tempo_metronome_core #(.TIME_BITS(TIME_BITS)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tt_status_checker #(.TIME_BITS(TIME_BITS)) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (checker_errors),
        .pending   (checker_pending),
        .beats     (checker_beats)
    );

    // Valid is only touched at falling edges, once per edge, so a word that follows
    // another without a gap keeps valid high. Ready only moves at rising edges, so it
    // is read at the falling edge before the edge that takes the word.
    task automatic send_word(input logic [OP_W-1:0] op, input logic [REQ_W-1:0] req,
                             input logic disp);
        begin
            @(negedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid <= 1'b1;
            in_word  <= '{op: op, tempo_value: req, display_active: disp};
            while (!in_ready)
            begin
                @(negedge clk);
            end
            @(posedge clk);
            case (op)
                OP_TICK:               n_ticks++;
                OP_TAP:                n_taps++;
                OP_SET_TEMPO:          n_sets++;
                OP_START, OP_STOP:     n_runstop++;
                default:               n_spare++;
            endcase
        end
    endtask

    task automatic send_tick();
        begin
            send_word(OP_TICK, REQ_W'($urandom_range(0, 1023)), $urandom_range(0, 3) != 0);
        end
    endtask

    task automatic send_other(input logic [OP_W-1:0] op);
        begin
            send_word(op, REQ_W'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic wait_drained();
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            while (checker_pending != 0)
            begin
                @(negedge clk);
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            @(negedge clk);
            cfg_we    <= 1'b0;
        end
    endtask

    task automatic set_config(input logic gig, input int tmo, input int plen);
        begin
            wait_drained();
            write_reg(CFG_GIG_MODE, CFG_DATA_W'(gig));
            write_reg(CFG_TAP_TMO, CFG_DATA_W'(tmo));
            write_reg(CFG_PULSE_LEN, CFG_DATA_W'(plen));
        end
    endtask

    // Mostly ticks, so beats and timeouts are reached; tap pairs spaced so that the
    // interval often lands in the legal tempo range.
    task automatic run_segment(input int n_items);
        int count;
        int pick;
        int gap;
        begin
            count = 0;
            while (count < n_items)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                begin
                    gap = $urandom_range(200, 700);
                    // Near the end of a segment the tap pair is squeezed to fit.
                    if (count + gap + 2 > n_items)
                    begin
                        gap = (n_items - count > 2) ? n_items - count - 2 : 0;
                    end
                    send_other(OP_TAP);
                    repeat (gap) send_tick();
                    send_other(OP_TAP);
                    count += gap + 2;
                end
                else if (pick < 6)
                begin
                    send_other(OP_START);
                    count++;
                end
                else if (pick < 7)
                begin
                    send_other(OP_STOP);
                    count++;
                end
                else if (pick < 11)
                begin
                    if ($urandom_range(0, 1) != 0)
                    begin
                        send_word(OP_SET_TEMPO, REQ_W'($urandom_range(0, 1023)), 1'b1);
                    end
                    else
                    begin
                        send_word(OP_SET_TEMPO, REQ_W'($urandom_range(TEMPO_MIN, TEMPO_MAX)),
                                  1'b0);
                    end
                    count++;
                end
                else if (pick < 13)
                begin
                    send_other(OP_TAP);
                    count++;
                end
                else if (pick < 14)
                begin
                    // Unused codes are ignored by the core and do not count.
                    send_other(OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)));
                end
                else if (pick < 15)
                begin
                    wait_drained();
                end
                else
                begin
                    send_tick();
                    count++;
                end
            end
        end
    endtask

    initial
    begin
        #2_000_000;
        $display("[tap_tempo_metronome_core] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int code;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_reg(CFG_SPARE, CFG_DATA_W'($urandom_range(0, 65535)));

        // Directed part with the reset register values.
        send_word(OP_TICK, '0, 1'b0);
        send_word(OP_TICK, '1, 1'b1);
        for (code = OP_SPARE_FIRST; code <= OP_SPARE_LAST; code++)
        begin
            send_word(OP_W'(code), '1, 1'b1);
        end
        send_word(OP_SET_TEMPO, '0, 1'b0);
        send_word(OP_SET_TEMPO, '1, 1'b0);
        send_word(OP_SET_TEMPO, REQ_W'(TEMPO_MIN - 1), 1'b0);
        send_word(OP_SET_TEMPO, REQ_W'(TEMPO_MAX + 1), 1'b1);
        send_word(OP_SET_TEMPO, REQ_W'(TEMPO_MIN), 1'b0);
        send_word(OP_SET_TEMPO, REQ_W'(TEMPO_MAX), 1'b1);
        send_word(OP_SET_TEMPO, REQ_W'(TEMPO_RESET), 1'b1);
        // A second tap in the same millisecond, then one a millisecond later whose
        // tempo would be far above the range.
        send_word(OP_TAP, '0, 1'b1);
        send_word(OP_TAP, '1, 1'b0);
        send_word(OP_TICK, '0, 1'b1);
        send_word(OP_TAP, '0, 1'b1);
        send_word(OP_START, '1, 1'b0);
        send_word(OP_TICK, '0, 1'b1);
        send_word(OP_SET_TEMPO, 10'd200, 1'b0);
        send_word(OP_TAP, '0, 1'b0);
        send_word(OP_STOP, '1, 1'b1);
        send_word(OP_TICK, '0, 1'b1);

        // Zero timeout and zero pulse length: tap mode ends on the next tick.
        set_config(1'b1, 0, 0);
        send_word(OP_TAP, '0, 1'b1);
        send_word(OP_TAP, '0, 1'b1);
        send_word(OP_TICK, '0, 1'b1);
        send_word(OP_TICK, '0, 1'b0);

        set_config(1'b0, 2000, 255);
        run_segment(400);
        set_config(1'b1, 1, 1);
        run_segment(150);

        wait_drained();
        send_idle_pct = 86;
        recv_idle_pct = 36;
        set_config(1'b1, 65535, 50);
        run_segment(400);
        set_config(1'b0, 300, 0);
        run_segment(150);

        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(1'b0, 400, 128);
        run_segment(550);

        wait_drained();
        repeat (100) @(negedge clk);

        $display("Covered %0d ticks, %0d taps, %0d tempo sets, %0d start/stop",
                 n_ticks, n_taps, n_sets, n_runstop);
        $display("and %0d unused codes, with %0d beats across seven register settings and three stall patterns.",
                 n_spare, checker_beats);
        if (checker_errors == 0 && checker_pending == 0)
        begin
            $display("[tap_tempo_metronome_core] OK");
        end
        else
        begin
            $display("[tap_tempo_metronome_core] ERROR");
        end
        $finish;
    end

endmodule
